// ----- src/ultrasonic_echo_trimmed_mean_defines.svh -----
// ----------------------------------------------------------------------------
// Ultrasonic echo trimmed mean: assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_TRIMMED_MEAN_DEFINES_SVH
`define ULTRASONIC_ECHO_TRIMMED_MEAN_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define UTE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ute assertion failed");

// next-cycle implication
`define UTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ute assertion failed");

`endif

// ----- src/ute_pkg.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo trimmed mean: package
// Widths, constants, sequencer states and divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package ute_pkg;

  localparam int unsigned DIST_W  = 30;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned TS_W    = 64;
  localparam int unsigned CPC_W   = 16;
  localparam int unsigned M_W     = 8;
  localparam int unsigned NBITS_W = 7;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [DIST_W-1:0] MIN_INIT  = 30'd593920000;
  localparam logic [CPC_W-1:0]  CPC_RESET = 16'd23200;
  localparam logic [M_W-1:0]    M_RESET   = 8'd5;
  localparam logic [CNT_W-1:0]  TRIM_EXTRA = 9'd2;

  // iteration counts for the two divisions
  localparam logic [NBITS_W-1:0] DIST_ITERS = 7'd64;
  localparam logic [NBITS_W-1:0] AVG_ITERS  = 7'd40;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic REG_SAMPLES = 1'b0;
  localparam logic REG_CPC     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_UPDATE,
    ST_TRIM,
    ST_AVG,
    ST_DONE
  } ute_state_e;

  typedef struct packed {
    logic                start;
    logic [TS_W-1:0]     dividend;
    logic [CPC_W-1:0]    divisor;
    logic [NBITS_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                ovf;
    logic [DIST_W-1:0]   quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/ute_div.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo trimmed mean: shared serial divider
// Restoring divider, one quotient bit per cycle, MSB first. The quotient is
// kept to 30 bits; any one bit shifted past that sets the overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ute_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ute_pkg::div_req_t   req_i,
  output ute_pkg::div_rsp_t   rsp_o
);

  logic [ute_pkg::TS_W-1:0]    dvd_q, dvd_d;
  logic [ute_pkg::CPC_W-1:0]   dvs_q, dvs_d;
  logic [ute_pkg::CPC_W-1:0]   rem_q, rem_d;
  logic [ute_pkg::DIST_W-1:0]  quot_q, quot_d;
  logic                        ovf_q, ovf_d;
  logic [ute_pkg::NBITS_W-1:0] cnt_q, cnt_d;

  logic [ute_pkg::CPC_W:0] rem_sh;
  logic [ute_pkg::CPC_W:0] rem_sub;
  logic                    ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[ute_pkg::TS_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});

    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;

    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quot_d = '0;
      ovf_d  = 1'b0;
      cnt_d  = req_i.nbits;
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[ute_pkg::TS_W-2:0], 1'b0};
      rem_d  = ge ? rem_sub[ute_pkg::CPC_W-1:0] : rem_sh[ute_pkg::CPC_W-1:0];
      quot_d = {quot_q[ute_pkg::DIST_W-2:0], ge};
      ovf_d  = ovf_q | quot_q[ute_pkg::DIST_W-1];
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.ovf      = ovf_q;
  assign rsp_o.quotient = quot_q;

endmodule

`default_nettype wire

// ----- src/ultrasonic_echo_trimmed_mean.sv -----
// Ultrasonic echo ranging with a trimmed mean over one run.
// Input channel (in_valid_i / in_stall_o): opcode_i 0 begins a run, 1 is an
// echo edge with timestamp_i. Edges alternate open / close; a closing edge
// yields one output beat (out_valid_o / out_stall_i side) with distance,
// sample number and, on sample m+2, the trimmed mean.
// Begin-run and opening-edge beats give no output.
// A closing edge goes through ST_DIST (distance division) and ST_UPDATE,
// then ST_TRIM and ST_AVG (mean division) when the mean is due, then ST_DONE.
// Both divisions run on one serial restoring divider, one bit per cycle;
// that divider sets the throughput. in_stall_o is high while a beat is in
// work. The output register holds a beat until taken; a finished beat
// waits for it to drain while the input stays stalled. A new input is
// taken while an earlier output beat still waits.
// The user must write configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only
// while idle; the block does not enforce this. Index 0 is samples_averaged
// (low 8 bits), index 1 is cycles_per_cm. Reset clears the run, the open
// edge and the output valid, and loads the registers with 5 and 23200.
// ----------------------------------------------------------------------------
// Ultrasonic echo trimmed mean: top level
// Sequencer, run accumulators and output register around a shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_trimmed_mean (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire                             cfg_idx_i,
  input  wire  [ute_pkg::CPC_W-1:0]       cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire                             opcode_i,
  input  wire  [ute_pkg::TS_W-1:0]        timestamp_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [ute_pkg::DIST_W-1:0]      distance_q6_o,
  output logic [ute_pkg::CNT_W-1:0]       sample_number_o,
  output logic                            average_valid_o,
  output logic [ute_pkg::DIST_W-1:0]      average_q6_o
);

  ute_pkg::ute_state_e state_q, state_d;

  logic [ute_pkg::M_W-1:0]    m_q;
  logic [ute_pkg::CPC_W-1:0]  cpc_q;

  logic                       open_q, open_d;
  logic [ute_pkg::TS_W-1:0]   start_q, start_d;
  logic [ute_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [ute_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [ute_pkg::DIST_W-1:0] min_q, min_d;
  logic [ute_pkg::DIST_W-1:0] max_q, max_d;

  logic                       big_q, big_d;
  logic [ute_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [ute_pkg::DIST_W-1:0] avg_q, avg_d;
  logic                       hit_q, hit_d;

  logic                       ovld_q, ovld_d;
  logic [ute_pkg::DIST_W-1:0] odist_q, odist_d;
  logic [ute_pkg::CNT_W-1:0]  onum_q, onum_d;
  logic                       oavv_q, oavv_d;
  logic [ute_pkg::DIST_W-1:0] oavg_q, oavg_d;

  ute_pkg::div_req_t div_req;
  ute_pkg::div_rsp_t div_rsp;

  logic                         in_acc;
  logic [ute_pkg::TS_W-1:0]     elapsed;
  logic [ute_pkg::SUM_W:0]      sum_add;
  logic [ute_pkg::CNT_W-1:0]    cnt_inc;
  logic [ute_pkg::DIST_W:0]     drop;
  logic [ute_pkg::SUM_W-1:0]    trimmed;

  ute_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != ute_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= ute_pkg::M_RESET;
      cpc_q <= ute_pkg::CPC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ute_pkg::REG_SAMPLES: m_q   <= cfg_data_i[ute_pkg::M_W-1:0];
        ute_pkg::REG_CPC:     cpc_q <= cfg_data_i;
        default:              m_q   <= m_q;
      endcase
    end
  end

  always_comb begin
    elapsed = timestamp_i - start_q;
    sum_add = {1'b0, sum_q} + {{(ute_pkg::SUM_W-ute_pkg::DIST_W+1){1'b0}}, dist_q};
    cnt_inc = (cnt_q == ute_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
    drop    = {1'b0, max_q} + {1'b0, min_q};
    trimmed = (sum_q > {{(ute_pkg::SUM_W-ute_pkg::DIST_W-1){1'b0}}, drop})
              ? sum_q - {{(ute_pkg::SUM_W-ute_pkg::DIST_W-1){1'b0}}, drop}
              : '0;

    state_d = state_q;
    open_d  = open_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    big_d   = big_q;
    dist_d  = dist_q;
    avg_d   = avg_q;
    hit_d   = hit_q;

    ovld_d  = ovld_q && out_stall_i;
    odist_d = odist_q;
    onum_d  = onum_q;
    oavv_d  = oavv_q;
    oavg_d  = oavg_q;

    div_req.start    = 1'b0;
    div_req.dividend = {elapsed[ute_pkg::TS_W-7:0], 6'b0};
    div_req.divisor  = cpc_q;
    div_req.nbits    = ute_pkg::DIST_ITERS;

    case (state_q)
      ute_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == ute_pkg::OP_BEGIN) begin
            if (!open_q) begin
              cnt_d = '0;
              sum_d = '0;
              min_d = ute_pkg::MIN_INIT;
              max_d = '0;
            end
          end else if (!open_q) begin
            open_d  = 1'b1;
            start_d = timestamp_i;
          end else begin
            open_d        = 1'b0;
            // elapsed*64 would pass 64 bits: distance saturates anyway
            big_d         = (elapsed[ute_pkg::TS_W-1:ute_pkg::TS_W-6] != '0);
            div_req.start = 1'b1;
            state_d       = ute_pkg::ST_DIST;
          end
        end
      end
      ute_pkg::ST_DIST: begin
        if (!div_rsp.busy) begin
          dist_d  = (div_rsp.ovf || big_q) ? ute_pkg::DIST_MAX : div_rsp.quotient;
          state_d = ute_pkg::ST_UPDATE;
        end
      end
      ute_pkg::ST_UPDATE: begin
        sum_d   = sum_add[ute_pkg::SUM_W] ? ute_pkg::SUM_MAX : sum_add[ute_pkg::SUM_W-1:0];
        min_d   = (dist_q < min_q) ? dist_q : min_q;
        max_d   = (dist_q > max_q) ? dist_q : max_q;
        cnt_d   = cnt_inc;
        avg_d   = '0;
        hit_d   = (cnt_inc == ({1'b0, m_q} + ute_pkg::TRIM_EXTRA));
        state_d = hit_d ? ute_pkg::ST_TRIM : ute_pkg::ST_DONE;
      end
      ute_pkg::ST_TRIM: begin
        // zero m divides to all ones, which then saturates to the max
        div_req.start    = 1'b1;
        div_req.dividend = {trimmed, {(ute_pkg::TS_W-ute_pkg::SUM_W){1'b0}}};
        div_req.divisor  = {{(ute_pkg::CPC_W-ute_pkg::M_W){1'b0}}, m_q};
        div_req.nbits    = ute_pkg::AVG_ITERS;
        state_d          = ute_pkg::ST_AVG;
      end
      ute_pkg::ST_AVG: begin
        if (!div_rsp.busy) begin
          avg_d   = div_rsp.ovf ? ute_pkg::DIST_MAX : div_rsp.quotient;
          state_d = ute_pkg::ST_DONE;
        end
      end
      ute_pkg::ST_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          odist_d = dist_q;
          onum_d  = cnt_q;
          oavv_d  = hit_q;
          oavg_d  = avg_q;
          state_d = ute_pkg::ST_IDLE;
        end
      end
      default: state_d = ute_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ute_pkg::ST_IDLE;
      open_q  <= 1'b0;
      start_q <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      min_q   <= ute_pkg::MIN_INIT;
      max_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    big_q   <= big_d;
    dist_q  <= dist_d;
    avg_q   <= avg_d;
    hit_q   <= hit_d;
    odist_q <= odist_d;
    onum_q  <= onum_d;
    oavv_q  <= oavv_d;
    oavg_q  <= oavg_d;
  end

  assign out_valid_o     = ovld_q;
  assign distance_q6_o   = odist_q;
  assign sample_number_o = onum_q;
  assign average_valid_o = oavv_q;
  assign average_q6_o    = oavg_q;

endmodule

`default_nettype wire

// ----- src/ute_checker.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo trimmed mean: port checker
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_echo_trimmed_mean_defines.svh"

module ute_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             out_valid_o,
  input wire                             out_stall_i,
  input wire [ute_pkg::DIST_W-1:0]       distance_q6_o,
  input wire [ute_pkg::CNT_W-1:0]        sample_number_o,
  input wire                             average_valid_o,
  input wire [ute_pkg::DIST_W-1:0]       average_q6_o
);

  // a stalled output beat stays put
  `UTE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(distance_q6_o) && $stable(average_q6_o))

  // every reported sample counts from one
  `UTE_ASSERT_IMPL(a_num_nonzero, out_valid_o, sample_number_o != '0)

  // the mean needs at least the two trimmed samples
  `UTE_ASSERT_IMPL(a_avg_count, out_valid_o && average_valid_o, sample_number_o >= ute_pkg::TRIM_EXTRA)

  // no mean reported, field reads zero
  `UTE_ASSERT_IMPL(a_avg_zero, out_valid_o && !average_valid_o, average_q6_o == '0)

endmodule

bind ultrasonic_echo_trimmed_mean ute_checker u_ute_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .distance_q6_o   (distance_q6_o),
  .sample_number_o (sample_number_o),
  .average_valid_o (average_valid_o),
  .average_q6_o    (average_q6_o)
);

`default_nettype wire
